### rtl/hlc_pkg.sv
// shared types and constants for the handheld link capture and packet port
`timescale 1ns / 1ps
`default_nettype none
package hlc_pkg;

    typedef enum logic [2:0] {
        MODE_LINE_RESET  = 3'd0,
        MODE_FRAME_RESET = 3'd1,
        MODE_PIXEL       = 3'd2,
        MODE_JOYP_WRITE  = 3'd3,
        MODE_BUS_READ    = 3'd4,
        MODE_BUS_WRITE   = 3'd5
    } mode_t;

    // lock flag bit positions
    localparam int LK_ID     = 0;
    localparam int LK_PULSE  = 1;
    localparam int LK_STROBE = 2;
    localparam int LK_PACKET = 3;
    localparam logic [3:0] LOCK_RESET = 4'b0011;

    localparam logic [23:0] RD_MASK      = 24'h40ffff;
    localparam logic [23:0] ADDR_LY      = 24'h006000;
    localparam logic [23:0] ADDR_POP     = 24'h006002;
    localparam logic [23:0] ADDR_VER     = 24'h00600f;
    localparam logic [23:0] ADDR_TILE_RD = 24'h007800;
    localparam logic [7:0]  VERSION      = 8'h21;
    localparam logic [15:0] ADDR_RBANK   = 16'h6001;
    localparam logic [15:0] ADDR_CTRL    = 16'h6003;
    localparam logic [13:0] ADDR_PAD_HI  = 14'h1801;
    localparam logic [11:0] ADDR_CMD_HI  = 12'h700;

endpackage
`default_nettype wire

### rtl/handheld_link_capture_and_packet_port_core.sv
// top level: pixel capture, joypad answer and command packet queue
// an accepted request waits in the held-item stage, then its result is registered (stalls hold it)
// a new request is taken only after the held one moves on, set by the tile store read-modify-write
// tile store is two 1024x8 synchronous rams (even and odd plane bytes)
// reset (and soft reset) runs a pass over all 1024 addresses filling the tile store with 0xff;
//   s_tready stays low during it
`timescale 1ns / 1ps
`default_nettype none
module handheld_link_capture_and_packet_port_core
    import hlc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int LINE_PIXELS = 160
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode[2:0], pixel_color[4:3], select_dpad_line[5], select_button_line[6],
    // bus_address[30:7], bus_data[38:31], zero[39]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[7:0], pad_nibble[11:8], pad_nibble_valid[12],
    // handheld_reset_pulse[13], handheld_running[14], clock_divider_select[16:15],
    // zero[23:17]
    output logic [23:0]      m_tdata
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] QD_C = CW'(QUEUE_DEPTH);
    localparam logic [QW:0] QD_S = (QW+1)'(QUEUE_DEPTH);
    localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [7:0] LP = 8'(LINE_PIXELS);

    // memories
    logic [7:0]   tile_even_mem [1024];
    logic [7:0]   tile_odd_mem  [1024];
    logic [127:0] queue_mem [QUEUE_DEPTH];
    logic [7:0]   even_q_reg, odd_q_reg;
    logic [127:0] queue_q_reg;

    // item held for the state update stage
    logic         st2_reg;
    logic [2:0]   it_mode_reg;
    logic [1:0]   it_color_reg;
    logic         it_p14_reg, it_p15_reg;
    logic [23:0]  it_addr_reg;
    logic [7:0]   it_data_reg;

    logic         m_valid_reg;
    logic [23:0]  m_data_reg;

    logic         clr_reg, clr_next;
    logic [9:0]   clr_addr_reg, clr_addr_next;

    // block state
    logic [CW-1:0] qcount_reg, qcount_next;
    logic [QW-1:0] qhead_reg, qhead_next;
    logic [7:0]    cmd_reg [16];
    logic [7:0]    cmd_next [16];
    logic [7:0]    asm_reg [16];
    logic [7:0]    asm_next [16];
    logic [7:0]    shifter_reg, shifter_next;
    logic [2:0]    bit_idx_reg, bit_idx_next;
    logic [3:0]    byte_idx_reg, byte_idx_next;
    logic [1:0]    pid_reg, pid_next;
    logic [3:0]    lock_reg, lock_next;
    logic [1:0]    rbank_reg, rbank_next;
    logic [8:0]    rptr_reg, rptr_next;
    logic [1:0]    wbank_reg, wbank_next;
    logic [7:0]    ctrl_reg, ctrl_next;
    logic [7:0]    pad_reg [4];
    logic [7:0]    pad_next [4];
    logic [7:0]    px_reg, px_next;
    logic [7:0]    ly_reg, ly_next;

    logic          accept, st2_go;
    logic          tile_re;
    logic [9:0]    tile_raddr;
    logic          tile_we;
    logic [9:0]    tile_waddr;
    logic [7:0]    wd_even, wd_odd;
    logic          pix_we;
    logic          q_we;
    logic [QW-1:0] q_waddr;
    logic [QW:0]   tail_sum;
    logic          soft_rst;
    logic [7:0]    rd_val;
    logic [3:0]    nib_val;
    logic          nv_val, pulse_val;
    logic [23:0]   in_addr, rd_addr;
    mode_t         in_mode, it_mode;

    assign s_tready = !st2_reg && !clr_reg;
    assign accept   = s_tvalid && s_tready;
    assign st2_go   = st2_reg && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign in_mode = mode_t'(s_tdata[2:0]);
    assign in_addr = s_tdata[30:7] & RD_MASK;
    assign it_mode = mode_t'(it_mode_reg);
    assign rd_addr = it_addr_reg & RD_MASK;

    // request stage: issue memory reads
    always_comb begin
        tile_re    = 1'b0;
        tile_raddr = {wbank_reg, px_reg[7:3], ly_reg[2:0]};
        if (accept && in_mode == MODE_PIXEL) begin
            tile_re = 1'b1;
        end else if (accept && in_mode == MODE_BUS_READ && in_addr == ADDR_TILE_RD) begin
            tile_re    = 1'b1;
            tile_raddr = {rbank_reg, rptr_reg[8:1]};
        end
    end

    // tile store write port shared with the clearing pass
    always_comb begin
        tile_we    = clr_reg || pix_we;
        tile_waddr = clr_reg ? clr_addr_reg : {wbank_reg, px_reg[7:3], ly_reg[2:0]};
        wd_even    = clr_reg ? 8'hff : {even_q_reg[6:0], it_color_reg[0]};
        wd_odd     = clr_reg ? 8'hff : {odd_q_reg[6:0], it_color_reg[1]};
    end

    always_ff @(posedge aclk) begin
        if (tile_we) begin
            tile_even_mem[tile_waddr] <= wd_even;
            tile_odd_mem[tile_waddr]  <= wd_odd;
        end
        if (tile_re) begin
            even_q_reg <= tile_even_mem[tile_raddr];
            odd_q_reg  <= tile_odd_mem[tile_raddr];
        end
    end

    assign tail_sum = (QW+1)'(qhead_reg) + (QW+1)'(qcount_reg);
    assign q_waddr  = (tail_sum >= QD_S) ? QW'(tail_sum - QD_S) : QW'(tail_sum);

    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= {asm_reg[15], asm_reg[14], asm_reg[13], asm_reg[12],
                                   asm_reg[11], asm_reg[10], asm_reg[9], asm_reg[8],
                                   asm_reg[7], asm_reg[6], asm_reg[5], asm_reg[4],
                                   asm_reg[3], asm_reg[2], asm_reg[1], asm_reg[0]};
        end
        if (accept && in_mode == MODE_BUS_READ && in_addr == ADDR_POP) begin
            queue_q_reg <= queue_mem[qhead_reg];
        end
    end

    // held-item stage: update state and form the result
    always_comb begin
        logic       p14, p15, bitv, done;
        logic [1:0] mlt;
        logic [7:0] pad;
        logic [3:0] nib;

        qcount_next   = qcount_reg;
        qhead_next    = qhead_reg;
        cmd_next      = cmd_reg;
        asm_next      = asm_reg;
        shifter_next  = shifter_reg;
        bit_idx_next  = bit_idx_reg;
        byte_idx_next = byte_idx_reg;
        pid_next      = pid_reg;
        lock_next     = lock_reg;
        rbank_next    = rbank_reg;
        rptr_next     = rptr_reg;
        wbank_next    = wbank_reg;
        ctrl_next     = ctrl_reg;
        pad_next      = pad_reg;
        px_next       = px_reg;
        ly_next       = ly_reg;
        pix_we        = 1'b0;
        q_we          = 1'b0;
        soft_rst      = 1'b0;
        rd_val        = 8'h00;
        nib_val       = 4'h0;
        nv_val        = 1'b0;
        pulse_val     = 1'b0;
        p14           = it_p14_reg;
        p15           = it_p15_reg;
        bitv          = 1'b0;
        done          = 1'b0;
        mlt           = ctrl_reg[5:4];
        pad           = 8'h00;
        nib           = 4'hf;

        if (st2_go) begin
            case (it_mode)
                MODE_LINE_RESET: begin
                    px_next = 8'h00;
                    ly_next = ly_reg + 8'd1;
                    if (ly_next[2:0] == 3'd0) begin
                        wbank_next = wbank_reg + 2'd1;
                    end
                end
                MODE_FRAME_RESET: begin
                    px_next = 8'h00;
                    ly_next = 8'h00;
                end
                MODE_PIXEL: begin
                    px_next = px_reg + 8'd1;
                    pix_we  = (px_reg < LP);
                end
                MODE_JOYP_WRITE: begin
                    nv_val = 1'b1;
                    if (p14 && p15 && !lock_reg[LK_ID]) begin
                        lock_next[LK_ID] = 1'b1;
                        pid_next = pid_reg + 2'd1;
                        if (mlt == 2'd0) begin
                            pid_next = 2'd0;
                        end else if (mlt == 2'd1) begin
                            pid_next[1] = 1'b0;
                        end
                    end
                    pad = pad_reg[pid_next];
                    if (p14 && p15) begin
                        nib = 4'hf - {2'b00, pid_next};
                    end
                    if (!p14) begin
                        nib = nib & pad[3:0];
                    end
                    if (!p15) begin
                        nib = nib & pad[7:4];
                    end
                    if (p14 && !p15) begin
                        lock_next[LK_ID] = !lock_next[LK_ID];
                    end
                    nib_val = nib;

                    if (!p14 && !p15) begin
                        lock_next[LK_PULSE]  = 1'b0;
                        lock_next[LK_PACKET] = 1'b0;
                        lock_next[LK_STROBE] = 1'b1;
                        byte_idx_next = 4'd0;
                        bit_idx_next  = 3'd0;
                    end else if (lock_next[LK_PULSE]) begin
                        done = 1'b1;
                    end else if (p14 && p15) begin
                        lock_next[LK_STROBE] = 1'b0;
                    end else begin
                        if (lock_next[LK_STROBE]) begin
                            // one line high while the strobe is still held: malformed packet
                            lock_next[LK_PACKET] = 1'b0;
                            lock_next[LK_PULSE]  = 1'b1;
                            bit_idx_next  = 3'd0;
                            byte_idx_next = 4'd0;
                        end
                        bitv = !p15;
                        lock_next[LK_STROBE] = 1'b1;
                        if (lock_next[LK_PACKET]) begin
                            if (!p14 && p15) begin
                                q_we = (qcount_reg < QD_C);
                                if (q_we) begin
                                    qcount_next = qcount_reg + CW'(1);
                                end
                                lock_next[LK_PACKET] = 1'b0;
                                lock_next[LK_PULSE]  = 1'b1;
                            end
                        end else begin
                            shifter_next = {bitv, shifter_reg[7:1]};
                            bit_idx_next = bit_idx_next + 3'd1;
                            if (bit_idx_next == 3'd0) begin
                                asm_next[byte_idx_next] = shifter_next;
                                byte_idx_next = byte_idx_next + 4'd1;
                                if (byte_idx_next == 4'd0) begin
                                    lock_next[LK_PACKET] = 1'b1;
                                end
                            end
                        end
                    end
                    if (done) begin
                        nib_val = nib;
                    end
                end
                MODE_BUS_READ: begin
                    if (rd_addr == ADDR_LY) begin
                        rd_val = {ly_reg[7:3], 1'b0, wbank_reg};
                    end else if (rd_addr == ADDR_POP) begin
                        if (qcount_reg != CW'(0)) begin
                            for (int i = 0; i < 16; i++) begin
                                cmd_next[i] = queue_q_reg[i*8 +: 8];
                            end
                            qcount_next = qcount_reg - CW'(1);
                            qhead_next  = (qhead_reg == QLAST) ? QW'(0) : qhead_reg + QW'(1);
                            rd_val      = 8'h01;
                        end
                    end else if (rd_addr == ADDR_VER) begin
                        rd_val = VERSION;
                    end else if (rd_addr[22] == 1'b0 && rd_addr[15:4] == ADDR_CMD_HI) begin
                        rd_val = cmd_reg[rd_addr[3:0]];
                    end else if (rd_addr == ADDR_TILE_RD) begin
                        rd_val    = rptr_reg[0] ? odd_q_reg : even_q_reg;
                        rptr_next = rptr_reg + 9'd1;
                    end
                end
                MODE_BUS_WRITE: begin
                    if (it_addr_reg[15:0] == ADDR_RBANK) begin
                        rbank_next = it_data_reg[1:0];
                        rptr_next  = 9'd0;
                    end else if (it_addr_reg[15:0] == ADDR_CTRL) begin
                        if (!ctrl_reg[7] && it_data_reg[7]) begin
                            soft_rst      = 1'b1;
                            pulse_val     = 1'b1;
                            qcount_next   = '0;
                            qhead_next    = '0;
                            for (int i = 0; i < 16; i++) begin
                                cmd_next[i] = 8'h00;
                                asm_next[i] = 8'h00;
                            end
                            shifter_next  = 8'h00;
                            bit_idx_next  = 3'd0;
                            byte_idx_next = 4'd0;
                            pid_next      = 2'd0;
                            lock_next     = LOCK_RESET;
                            rbank_next    = 2'd0;
                            rptr_next     = 9'd0;
                            wbank_next    = 2'd0;
                            for (int i = 0; i < 4; i++) begin
                                pad_next[i] = 8'hff;
                            end
                            px_next       = 8'h00;
                            ly_next       = 8'h00;
                        end
                        if (it_data_reg[5:4] == 2'd1) begin
                            pid_next[0] = 1'b0;
                        end else if (it_data_reg[5:4] != 2'd0) begin
                            pid_next = 2'd0;
                        end
                        ctrl_next = it_data_reg;
                    end else if (it_addr_reg[15:2] == ADDR_PAD_HI) begin
                        pad_next[it_addr_reg[1:0]] = it_data_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg) begin
            clr_addr_next = clr_addr_reg + 10'd1;
            if (clr_addr_reg == 10'h3ff) begin
                clr_next = 1'b0;
            end
        end
        if (soft_rst) begin
            clr_next      = 1'b1;
            clr_addr_next = 10'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            it_mode_reg  <= s_tdata[2:0];
            it_color_reg <= s_tdata[4:3];
            it_p14_reg   <= s_tdata[5];
            it_p15_reg   <= s_tdata[6];
            it_addr_reg  <= s_tdata[30:7];
            it_data_reg  <= s_tdata[38:31];
        end
        if (st2_go) begin
            m_data_reg <= {7'd0, ctrl_next[1:0], ctrl_next[7], pulse_val, nv_val,
                           nib_val, rd_val};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= 10'd0;
            qcount_reg   <= '0;
            qhead_reg    <= '0;
            for (int i = 0; i < 16; i++) begin
                cmd_reg[i] <= 8'h00;
                asm_reg[i] <= 8'h00;
            end
            shifter_reg  <= 8'h00;
            bit_idx_reg  <= 3'd0;
            byte_idx_reg <= 4'd0;
            pid_reg      <= 2'd0;
            lock_reg     <= LOCK_RESET;
            rbank_reg    <= 2'd0;
            rptr_reg     <= 9'd0;
            wbank_reg    <= 2'd0;
            ctrl_reg     <= 8'h00;
            for (int i = 0; i < 4; i++) begin
                pad_reg[i] <= 8'hff;
            end
            px_reg       <= 8'h00;
            ly_reg       <= 8'h00;
        end else begin
            if (accept) begin
                st2_reg <= 1'b1;
            end else if (st2_go) begin
                st2_reg <= 1'b0;
            end
            if (st2_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            qcount_reg   <= qcount_next;
            qhead_reg    <= qhead_next;
            cmd_reg      <= cmd_next;
            asm_reg      <= asm_next;
            shifter_reg  <= shifter_next;
            bit_idx_reg  <= bit_idx_next;
            byte_idx_reg <= byte_idx_next;
            pid_reg      <= pid_next;
            lock_reg     <= lock_next;
            rbank_reg    <= rbank_next;
            rptr_reg     <= rptr_next;
            wbank_reg    <= wbank_next;
            ctrl_reg     <= ctrl_next;
            pad_reg      <= pad_next;
            px_reg       <= px_next;
            ly_reg       <= ly_next;
        end
    end

endmodule
`default_nettype wire

### bench/tb_handheld_link_capture_and_packet_port_core.sv
// self-checking bench for the handheld link capture and packet port core
`timescale 1ns / 1ps
module tb_handheld_link_capture_and_packet_port_core;
    import hlc_pkg::*;

    localparam int SLOTS = 64;
    localparam int LINE_W = 160;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam logic [23:0] ADDR_CMD0 = 24'h007000;
    localparam logic [23:0] ADDR_RBANK_RD = 24'h006001;
    localparam logic [23:0] ADDR_CTRL_WR = 24'h006003;
    localparam logic [23:0] ADDR_PAD0 = 24'h006004;

    // first member sits in the highest bits of m_tdata[16:0]
    typedef struct packed {
        logic [1:0] clk_sel;
        logic       running;
        logic       rst_pulse;
        logic       nib_vld;
        logic [3:0] nib;
        logic [7:0] rd;
    } port_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    handheld_link_capture_and_packet_port_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the port state
    logic [7:0] tiles[2048];
    logic [7:0] cmd_fifo[SLOTS][16];
    int         fifo_count, fifo_head;
    logic [7:0] cmd_regs[16];
    logic [7:0] pkt_bytes[16];
    logic [7:0] shifter;
    logic [2:0] bit_i;
    logic [3:0] byte_i;
    logic [1:0] pid;
    logic [3:0] lk;
    logic [1:0] rbank;
    logic [8:0] rptr;
    logic [1:0] wbank;
    logic [7:0] ctrl;
    logic [7:0] pads[4];
    logic [7:0] px, ly;

    function automatic void clear_port();
        for (int i = 0; i < 2048; i++) tiles[i] = 8'hff;
        for (int i = 0; i < 16; i++) begin
            cmd_regs[i] = '0;
            pkt_bytes[i] = '0;
        end
        for (int i = 0; i < 4; i++) pads[i] = 8'hff;
        fifo_count = 0; fifo_head = 0;
        shifter = '0; bit_i = '0; byte_i = '0; pid = '0;
        lk = LOCK_RESET; rbank = '0; rptr = '0; wbank = '0; ctrl = '0;
        px = '0; ly = '0;
    endfunction

    function automatic void shift_pixel(logic [1:0] color);
        int x, a;
        x = px;
        px = px + 8'd1;
        if (x >= LINE_W) return;
        a = (wbank * 512 + ly[2:0] * 2 + (x / 8) * 16) & 2047;
        tiles[a] = {tiles[a][6:0], color[0]};
        tiles[(a + 1) & 2047] = {tiles[(a + 1) & 2047][6:0], color[1]};
    endfunction

    function automatic logic [3:0] answer_select(logic p14, logic p15);
        logic [1:0] mlt;
        logic [7:0] pad;
        logic [3:0] nib;
        logic       b;
        mlt = ctrl[5:4];
        nib = 4'hf;
        if (p14 && p15 && !lk[LK_ID]) begin
            lk[LK_ID] = 1'b1;
            pid = pid + 2'd1;
            if (mlt == 2'd0) pid = 2'd0;
            else if (mlt == 2'd1) pid[1] = 1'b0;
        end
        pad = pads[pid];
        if (p14 && p15) nib = 4'hf - pid;
        if (!p14) nib &= pad[3:0];
        if (!p15) nib &= pad[7:4];
        if (p14 && !p15) lk[LK_ID] = ~lk[LK_ID];
        if (!p14 && !p15) begin
            lk[LK_PULSE] = 1'b0;
            lk[LK_PACKET] = 1'b0;
            lk[LK_STROBE] = 1'b1;
            byte_i = '0;
            bit_i = '0;
            return nib;
        end
        if (lk[LK_PULSE]) return nib;
        if (p14 && p15) begin
            lk[LK_STROBE] = 1'b0;
            return nib;
        end
        // strobe still held: sequence is broken, restart it
        if (lk[LK_STROBE]) begin
            lk[LK_PACKET] = 1'b0;
            lk[LK_PULSE] = 1'b1;
            bit_i = '0;
            byte_i = '0;
        end
        b = !p15;
        lk[LK_STROBE] = 1'b1;
        if (lk[LK_PACKET]) begin
            if (!p14 && p15) begin
                if (fifo_count < SLOTS)
                    begin
                    for (int i = 0; i < 16; i++)
                        cmd_fifo[(fifo_head + fifo_count) % SLOTS][i] = pkt_bytes[i];
                    fifo_count++;
                end
                lk[LK_PACKET] = 1'b0;
                lk[LK_PULSE] = 1'b1;
            end
            return nib;
        end
        shifter = {b, shifter[7:1]};
        bit_i = bit_i + 3'd1;
        if (bit_i != 0) return nib;
        pkt_bytes[byte_i] = shifter;
        byte_i = byte_i + 4'd1;
        if (byte_i != 0) return nib;
        lk[LK_PACKET] = 1'b1;
        return nib;
    endfunction

    function automatic logic [7:0] host_read(logic [23:0] addr);
        logic [23:0] a;
        logic [7:0]  d;
        a = addr & RD_MASK;
        if (a == ADDR_LY) return {ly[7:3], 1'b0, wbank};
        if (a == ADDR_POP) begin
            if (fifo_count == 0) return 8'd0;
            for (int i = 0; i < 16; i++) cmd_regs[i] = cmd_fifo[fifo_head][i];
            fifo_count--;
            fifo_head = (fifo_head + 1) % SLOTS;
            return 8'd1;
        end
        if (a == ADDR_VER) return VERSION;
        if ((a & 24'h40fff0) == ADDR_CMD0) return cmd_regs[a[3:0]];
        if (a == ADDR_TILE_RD) begin
            d = tiles[(rbank * 512 + rptr) & 2047];
            rptr = rptr + 9'd1;
            return d;
        end
        return 8'd0;
    endfunction

    function automatic logic host_write(logic [23:0] addr, logic [7:0] data);
        logic [15:0] a;
        logic        pulse;
        a = addr[15:0];
        pulse = 1'b0;
        if (a == ADDR_RBANK) begin
            rbank = data[1:0];
            rptr = '0;
        end else if (a == ADDR_CTRL) begin
            if (!ctrl[7] && data[7]) begin
                clear_port();
                pulse = 1'b1;
            end
            if (data[5:4] == 2'd1) pid[0] = 1'b0;
            else if (data[5:4] >= 2'd2) pid = 2'd0;
            ctrl = data;
        end else if (a[15:2] == ADDR_PAD_HI) begin
            pads[a[1:0]] = data;
        end
        return pulse;
    endfunction

    function automatic port_result_t predict_port(logic [39:0] req);
        port_result_t r;
        r = '0;
        case (req[2:0])
            MODE_LINE_RESET: begin
                px = '0;
                ly = ly + 8'd1;
                if (ly[2:0] == 3'd0) wbank = wbank + 2'd1;
            end
            MODE_FRAME_RESET: begin
                px = '0;
                ly = '0;
            end
            MODE_PIXEL: shift_pixel(req[4:3]);
            MODE_JOYP_WRITE: begin
                r.nib = answer_select(req[5], req[6]);
                r.nib_vld = 1'b1;
            end
            MODE_BUS_READ: r.rd = host_read(req[30:7]);
            MODE_BUS_WRITE: r.rst_pulse = host_write(req[30:7], req[38:31]);
            default: ;
        endcase
        r.running = ctrl[7];
        r.clk_sel = ctrl[1:0];
        return r;
    endfunction

    // request generation; the helpers and the random mix fill unused fields with random bits
    logic [39:0]  pending_requests[$];
    port_result_t results_due[$];
    int send_idle = 0, recv_stall = 0;
    int errors = 0, accepted = 0, checked = 0, idle_cycles = 0;
    logic ctrl_hint = 1'b0;

    function automatic void add_req(logic [2:0] mode, logic [1:0] color, logic p14, logic p15,
                                    logic [23:0] addr, logic [7:0] data);
        pending_requests.push_back({1'b0, data, addr, p15, p14, color, mode});
    endfunction

    function automatic void add_select(logic p14, logic p15);
        add_req(MODE_JOYP_WRITE, 2'($urandom), p14, p15, 24'($urandom), 8'($urandom));
    endfunction

    function automatic void add_read(logic [23:0] addr);
        add_req(MODE_BUS_READ, 2'($urandom), 1'($urandom), 1'($urandom), addr, 8'($urandom));
    endfunction

    function automatic void add_write(logic [23:0] addr, logic [7:0] data);
        add_req(MODE_BUS_WRITE, 2'($urandom), 1'($urandom), 1'($urandom), addr, data);
    endfunction

    // well-formed command packet: reset strobe, 128 bit pulses, stop pulse
    function automatic void add_packet();
        add_select(1'b0, 1'b0);
        add_select(1'b1, 1'b1);
        for (int i = 0; i < 128; i++) begin
            if ($urandom_range(0, 1)) add_select(1'b1, 1'b0);
            else add_select(1'b0, 1'b1);
            add_select(1'b1, 1'b1);
        end
        add_select(1'b0, 1'b1);
        add_select(1'b1, 1'b1);
    endfunction

    function automatic logic [23:0] pick_addr();
        logic [23:0] a;
        case ($urandom_range(0, 7))
            0: a = ADDR_LY;
            1: a = ADDR_POP;
            2: a = ADDR_VER;
            3, 4: a = ADDR_CMD0 | 24'($urandom_range(0, 15));
            5: a = ADDR_TILE_RD;
            6: a = ADDR_RBANK_RD + 24'($urandom_range(0, 6));
            default: a = 24'($urandom);
        endcase
        // upper bits are mostly masked off on the way in
        if ($urandom_range(0, 3) == 0) a[23:16] = 8'($urandom);
        return a;
    endfunction

    function automatic void add_random();
        int    p;
        logic [7:0] d;
        p = $urandom_range(0, 99);
        if (p < 6) add_req(MODE_LINE_RESET, 2'($urandom), 1'($urandom), 1'($urandom),
                           24'($urandom), 8'($urandom));
        else if (p < 8) add_req(MODE_FRAME_RESET, 2'($urandom), 1'($urandom), 1'($urandom),
                                24'($urandom), 8'($urandom));
        else if (p < 38) add_req(MODE_PIXEL, 2'($urandom), 1'($urandom), 1'($urandom),
                                 24'($urandom), 8'($urandom));
        else if (p < 50) add_select(1'($urandom), 1'($urandom));
        else if (p < 78) add_read(pick_addr());
        else if (p < 96) begin
            d = 8'($urandom);
            // keep soft resets occasional since each runs a long clearing pass
            if (($urandom_range(0, 3) != 0)) d[7] = ctrl_hint;
            add_write(pick_addr(), d);
        end else add_req($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B, 2'($urandom),
                         1'($urandom), 1'($urandom), 24'($urandom), 8'($urandom));
    endfunction

    // driver: new request offered at the falling edge
    logic in_fire = 1'b0;
    always @(negedge aclk) begin
        if (!s_tvalid || in_fire) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_requests.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        port_result_t want, got;
        in_fire <= s_tvalid && s_tready && aresetn;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[16:0];
                checked++;
                if (results_due.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    if (got.rd !== want.rd) begin
                        $error("read_data exp %h got %h", want.rd, got.rd); errors++;
                    end
                    if (got.nib !== want.nib) begin
                        $error("pad_nibble exp %h got %h", want.nib, got.nib); errors++;
                    end
                    if (got.nib_vld !== want.nib_vld) begin
                        $error("pad_nibble_valid exp %b got %b", want.nib_vld, got.nib_vld);
                        errors++;
                    end
                    if (got.rst_pulse !== want.rst_pulse) begin
                        $error("handheld_reset_pulse exp %b got %b",
                               want.rst_pulse, got.rst_pulse);
                        errors++;
                    end
                    if (got.running !== want.running) begin
                        $error("handheld_running exp %b got %b", want.running, got.running);
                        errors++;
                    end
                    if (got.clk_sel !== want.clk_sel) begin
                        $error("clock_divider_select exp %h got %h", want.clk_sel, got.clk_sel);
                        errors++;
                    end
                    if (m_tdata[23:17] !== '0) begin
                        $error("m_tdata pad exp 0 got %h", m_tdata[23:17]); errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                results_due.push_back(predict_port(s_tdata));
                accepted++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_requests.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        int send_pct[4];
        int recv_pct[4];
        send_pct = '{0, 50, 0, 20};
        recv_pct = '{0, 0, 50, 20};
        clear_port();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, every mode, spare modes, masking, empty pop
        add_read(ADDR_VER);
        add_read(ADDR_POP);
        add_read(24'hffffff);
        add_read(24'h40600f);
        add_read(24'hbf600f);
        add_write(24'hff6004, 8'h00);
        add_write(24'h006007, 8'hff);
        add_write(24'h406005, 8'h5a);
        add_req(MODE_PIXEL, 2'd3, 1'b1, 1'b1, 24'hffffff, 8'hff);
        add_req(MODE_PIXEL, 2'd0, 1'b0, 1'b0, 24'h000000, 8'h00);
        add_req(MODE_SPARE_A, 2'd3, 1'b1, 1'b1, 24'hffffff, 8'hff);
        add_req(MODE_SPARE_B, 2'd0, 1'b0, 1'b0, 24'h000000, 8'h00);
        add_select(1'b1, 1'b1);
        add_select(1'b0, 1'b1);
        add_select(1'b1, 1'b0);
        add_select(1'b0, 1'b0);
        add_write(ADDR_CTRL_WR, 8'h33);
        add_select(1'b1, 1'b1);
        add_select(1'b1, 1'b0);
        add_select(1'b1, 1'b1);
        add_write(ADDR_CTRL_WR, 8'hb2);
        add_write(ADDR_CTRL_WR, 8'h21);
        add_req(MODE_LINE_RESET, 2'd0, 1'b0, 1'b0, 24'd0, 8'd0);
        add_req(MODE_FRAME_RESET, 2'd0, 1'b0, 1'b0, 24'd0, 8'd0);
        for (int i = 0; i < 4; i++) add_read(ADDR_TILE_RD);
        // one command packet through the queue, then pop it and pop the empty queue
        add_packet();
        add_read(ADDR_POP);
        for (int i = 0; i < 16; i++) add_read(ADDR_CMD0 | 24'(i));
        add_read(ADDR_POP);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle = send_pct[ph];
            recv_stall = recv_pct[ph];
            ctrl_hint = ph[0];
            for (int i = 0; i < 25; i++) add_random();
            drain();
        end
        drain();
        send_idle = 0;
        recv_stall = 0;
        repeat (20) @(posedge aclk);
        $display("covered pixel capture, select answers, a full packet through the queue,");
        $display("host reads and writes; %0d requests accepted, %0d results checked",
                 accepted, checked);
        if (errors == 0 && results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
